>>> hdl/pdc_pkg.sv
// Shared types, constants and codes of the progressive decimation capture block.
package pdc_pkg;

    localparam int RECENT_DEPTH_DEF  = 1024;
    localparam int ARCHIVE_DEPTH_DEF = 1024;

    localparam int SAMPLE_W      = 32;
    localparam int PAIR_W        = 2 * SAMPLE_W;
    localparam int READ_INDEX_W  = 11;
    localparam int TOTAL_W       = 12;
    localparam int ARCH_COUNT_W  = 11;
    localparam int STRIDE_W      = 32;

    localparam int S_TDATA_W = 80;   // 75 payload bits rounded up to whole bytes
    localparam int M_TDATA_W = 120;  // 119 payload bits rounded up to whole bytes

    localparam logic [STRIDE_W-1:0] STRIDE_MAX = 32'h8000_0000;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FOLD_RD,
        ST_FOLD_OFFER,
        ST_FOLD_WAIT,
        ST_DONE
    } pdc_state_t;

    typedef enum logic [1:0] {
        AS_IDLE,
        AS_COMPACT,
        AS_DRAIN
    } arc_state_t;

    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_RECENT,
        SRC_ARCHIVE
    } src_t;

    typedef struct packed {
        logic offer;
        logic rd_en;
    } arc_req_t;

    typedef struct packed {
        logic                busy;
        logic [STRIDE_W-1:0] stride;
    } arc_status_t;

endpackage

>>> hdl/pdc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
module pdc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1025
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/pdc_archive.sv
// Decimated archive: phase/stride bookkeeping, archive memory and odd-position compaction.
module pdc_archive #(
    parameter int ARCHIVE_DEPTH = pdc_pkg::ARCHIVE_DEPTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  pdc_pkg::arc_req_t                     req,
    input  logic [pdc_pkg::PAIR_W-1:0]            offer_data,
    input  logic [$clog2(ARCHIVE_DEPTH+1)-1:0]    rd_addr,
    output logic [pdc_pkg::PAIR_W-1:0]            rd_data,
    output logic [$clog2(ARCHIVE_DEPTH+2)-1:0]    fill,
    output pdc_pkg::arc_status_t                  status
);
    import pdc_pkg::*;

    localparam int AAW = $clog2(ARCHIVE_DEPTH + 1);
    localparam int AFW = $clog2(ARCHIVE_DEPTH + 2);

    arc_state_t          state_reg, state_next;
    logic [STRIDE_W-1:0] phase_reg, phase_next;
    logic [STRIDE_W-1:0] stride_reg, stride_next;
    logic [AFW-1:0]      fill_reg, fill_next;
    logic [AFW:0]        r_reg, r_next;
    logic [AFW-1:0]      w_reg, w_next;
    logic                pend_reg, pend_next;

    logic                we;
    logic [AAW-1:0]      waddr;
    logic [PAIR_W-1:0]   wdata;
    logic                re;
    logic [AAW-1:0]      raddr;
    logic [STRIDE_W-1:0] phase_inc;

    pdc_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (ARCHIVE_DEPTH + 1)
    ) u_mem (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= AS_IDLE;
            phase_reg  <= '0;
            stride_reg <= STRIDE_W'(1);
            fill_reg   <= '0;
            pend_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            stride_reg <= stride_next;
            fill_reg   <= fill_next;
            pend_reg   <= pend_next;
        end
        r_reg <= r_next;
        w_reg <= w_next;
    end

    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        stride_next = stride_reg;
        fill_next   = fill_reg;
        r_next      = r_reg;
        w_next      = w_reg;
        pend_next   = pend_reg;
        we          = 1'b0;
        waddr       = fill_reg[AAW-1:0];
        wdata       = offer_data;
        re          = req.rd_en;
        raddr       = rd_addr;
        phase_inc   = phase_reg + STRIDE_W'(1);

        // A read issued in the previous compaction cycle lands at the write pointer.
        if (pend_reg) begin
            we     = 1'b1;
            waddr  = w_reg[AAW-1:0];
            wdata  = rd_data;
            w_next = w_reg + AFW'(1);
        end

        case (state_reg)
            AS_IDLE: begin
                if (req.offer) begin
                    if (phase_inc < stride_reg) begin
                        phase_next = phase_inc;
                    end else begin
                        phase_next = '0;
                        we         = 1'b1;
                        fill_next  = fill_reg + AFW'(1);
                        if (fill_reg == AFW'(ARCHIVE_DEPTH)) begin
                            state_next = AS_COMPACT;
                            r_next     = (AFW+1)'(1);
                            w_next     = '0;
                        end
                    end
                end
            end
            AS_COMPACT: begin
                re        = 1'b1;
                raddr     = r_reg[AAW-1:0];
                pend_next = 1'b1;
                r_next    = r_reg + (AFW+1)'(2);
                if (r_reg + (AFW+1)'(2) > (AFW+1)'(ARCHIVE_DEPTH)) begin
                    state_next = AS_DRAIN;
                end
            end
            AS_DRAIN: begin
                pend_next   = 1'b0;
                fill_next   = w_reg + AFW'(1);
                stride_next = (stride_reg >= STRIDE_MAX) ? STRIDE_MAX : (stride_reg << 1);
                state_next  = AS_IDLE;
            end
            default: begin
                state_next = AS_IDLE;
            end
        endcase
    end

    assign fill          = fill_reg;
    assign status.busy   = (state_reg != AS_IDLE);
    assign status.stride = stride_reg;

endmodule

>>> hdl/progressive_decimation_capture.sv
// Top level of the progressive decimation capture store.
//
// One input channel (s_) carries requests: tuser selects a push of a
// (time, value) pair or a read of the entry at read_index in export order
// (archive oldest first, then recent oldest first). Every request yields
// exactly one result on the output channel (m_), carrying the read pair,
// a valid flag in tuser, the total and archive counts and the stride.
//
// A plain push or a read passes through ST_EXEC and then ST_DONE, where its
// result is loaded into the output register, and the sequencer is back in
// ST_IDLE for the next request in the following cycle, so plain requests do
// not overlap. A push that overflows the recent ring folds RECENT_DEPTH/2
// pairs into the archive, each by a read of the oldest pair from the recent
// memory and then an offer of it; each archive overflow holds the fold while
// the compaction walk moves the odd positions through the archive memory.
//
// One request is in flight at a time; s_tready is high while the sequencer
// is idle, so a new request is taken while a finished result still waits.
// When the receiver stalls, the result holds in the output register and the
// sequencer waits after finishing the next request. Reset empties both
// stores, sets the stride to one and drops m_tvalid.
module progressive_decimation_capture #(
    parameter int RECENT_DEPTH  = pdc_pkg::RECENT_DEPTH_DEF,
    parameter int ARCHIVE_DEPTH = pdc_pkg::ARCHIVE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // sample_time[31:0], sample_value[63:32], read_index[74:64], zero pad
    input  logic [pdc_pkg::S_TDATA_W-1:0]   s_tdata,
    // func[0]
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // read_time[31:0], read_value[63:32], total_count[75:64],
    // archive_count[86:76], stride_now[118:87], zero pad
    output logic [pdc_pkg::M_TDATA_W-1:0]   m_tdata,
    // read_valid[0]
    output logic                            m_tuser
);
    import pdc_pkg::*;

    localparam int RAW  = $clog2(RECENT_DEPTH + 1);
    localparam int RFW  = $clog2(RECENT_DEPTH + 2);
    localparam int AAW  = $clog2(ARCHIVE_DEPTH + 1);
    localparam int AFW  = $clog2(ARCHIVE_DEPTH + 2);
    localparam int FOLD = RECENT_DEPTH / 2;
    localparam int FCW  = $clog2(FOLD + 1);
    localparam int MW0  = (RFW > AFW) ? RFW : AFW;
    localparam int IW   = ((MW0 > READ_INDEX_W) ? MW0 : READ_INDEX_W) + 1;
    localparam int PADW = M_TDATA_W - (PAIR_W + TOTAL_W + ARCH_COUNT_W + STRIDE_W);

    pdc_state_t               state_reg, state_next;
    logic                     func_reg;
    logic [SAMPLE_W-1:0]      time_reg, value_reg;
    logic [READ_INDEX_W-1:0]  idx_reg;
    logic [RAW-1:0]           head_reg, head_next;
    logic [RAW-1:0]           tail_reg, tail_next;
    logic [RFW-1:0]           rfill_reg, rfill_next;
    logic [FCW-1:0]           fold_cnt_reg, fold_cnt_next;
    src_t                     src_reg, src_next;
    logic                     m_tvalid_reg;
    logic [M_TDATA_W-1:0]     m_tdata_reg;
    logic                     m_tuser_reg;
    logic                     load_out;

    // Recent ring memory.
    logic                     rec_we;
    logic [RAW-1:0]           rec_waddr;
    logic                     rec_re;
    logic [RAW-1:0]           rec_raddr;
    logic [PAIR_W-1:0]        rec_q;

    // Archive unit.
    arc_req_t                 arc_req;
    logic [AAW-1:0]           arc_raddr;
    logic [PAIR_W-1:0]        arc_q;
    logic [AFW-1:0]           afill;
    arc_status_t              arc_stat;

    // Export index arithmetic.
    logic [IW-1:0]            idx_ext, afill_ext, rfill_ext, total_ext;
    logic [IW-1:0]            rec_off, rec_sum;
    logic [RAW-1:0]           rec_addr;
    logic [PAIR_W-1:0]        rd_pair;

    pdc_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (RECENT_DEPTH + 1)
    ) u_recent (
        .aclk  (aclk),
        .we    (rec_we),
        .waddr (rec_waddr),
        .wdata ({value_reg, time_reg}),
        .re    (rec_re),
        .raddr (rec_raddr),
        .rdata (rec_q)
    );

    pdc_archive #(
        .ARCHIVE_DEPTH (ARCHIVE_DEPTH)
    ) u_archive (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (arc_req),
        .offer_data (rec_q),
        .rd_addr    (arc_raddr),
        .rd_data    (arc_q),
        .fill       (afill),
        .status     (arc_stat)
    );

    assign idx_ext   = IW'(idx_reg);
    assign afill_ext = IW'(afill);
    assign rfill_ext = IW'(rfill_reg);
    assign total_ext = afill_ext + rfill_ext;
    assign arc_raddr = idx_ext[AAW-1:0];

    // Position inside the recent ring, wrapped once around its depth.
    assign rec_off  = idx_ext - afill_ext;
    assign rec_sum  = IW'(head_reg) + rec_off;
    assign rec_addr = (rec_sum >= IW'(RECENT_DEPTH + 1)) ?
                      RAW'(rec_sum - IW'(RECENT_DEPTH + 1)) : RAW'(rec_sum);

    always_comb begin
        case (src_reg)
            SRC_RECENT:  rd_pair = rec_q;
            SRC_ARCHIVE: rd_pair = arc_q;
            default:     rd_pair = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            rfill_reg    <= '0;
            src_reg      <= SRC_NONE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            rfill_reg <= rfill_next;
            src_reg   <= src_next;
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        fold_cnt_reg <= fold_cnt_next;
        if (s_tvalid && s_tready) begin
            func_reg  <= s_tuser;
            time_reg  <= s_tdata[SAMPLE_W-1:0];
            value_reg <= s_tdata[PAIR_W-1:SAMPLE_W];
            idx_reg   <= s_tdata[PAIR_W+READ_INDEX_W-1:PAIR_W];
        end
        if (load_out) begin
            m_tdata_reg <= {{PADW{1'b0}}, arc_stat.stride, ARCH_COUNT_W'(afill),
                            TOTAL_W'(total_ext), rd_pair};
            m_tuser_reg <= (src_reg != SRC_NONE);
        end
    end

    // Request sequencer: push, read, and the fold walk into the archive.
    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        rfill_next    = rfill_reg;
        fold_cnt_next = fold_cnt_reg;
        src_next      = src_reg;
        rec_we        = 1'b0;
        rec_waddr     = tail_reg;
        rec_re        = 1'b0;
        rec_raddr     = rec_addr;
        arc_req.offer = 1'b0;
        arc_req.rd_en = 1'b0;
        load_out      = 1'b0;
        s_tready      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (func_reg == FUNC_PUSH) begin
                    src_next   = SRC_NONE;
                    rec_we     = 1'b1;
                    tail_next  = (tail_reg == RAW'(RECENT_DEPTH)) ? '0 : tail_reg + RAW'(1);
                    rfill_next = rfill_reg + RFW'(1);
                    if (rfill_reg == RFW'(RECENT_DEPTH)) begin
                        fold_cnt_next = '0;
                        state_next    = ST_FOLD_RD;
                    end else begin
                        state_next = ST_DONE;
                    end
                end else begin
                    if (idx_ext < afill_ext) begin
                        arc_req.rd_en = 1'b1;
                        src_next      = SRC_ARCHIVE;
                    end else if (idx_ext < total_ext) begin
                        rec_re   = 1'b1;
                        src_next = SRC_RECENT;
                    end else begin
                        src_next = SRC_NONE;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_FOLD_RD: begin
                // Oldest recent pair leaves the ring; its data is ready next cycle.
                rec_re     = 1'b1;
                rec_raddr  = head_reg;
                head_next  = (head_reg == RAW'(RECENT_DEPTH)) ? '0 : head_reg + RAW'(1);
                rfill_next = rfill_reg - RFW'(1);
                state_next = ST_FOLD_OFFER;
            end
            ST_FOLD_OFFER: begin
                if (!arc_stat.busy) begin
                    arc_req.offer = 1'b1;
                    fold_cnt_next = fold_cnt_reg + FCW'(1);
                    if (fold_cnt_reg == FCW'(FOLD - 1)) begin
                        state_next = ST_FOLD_WAIT;
                    end else begin
                        state_next = ST_FOLD_RD;
                    end
                end
            end
            ST_FOLD_WAIT: begin
                // The last offer may have started a compaction walk.
                if (!arc_stat.busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> hdl/pdc_checker.sv
// Port-level checker for the progressive decimation capture block, with its bind.
module pdc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [pdc_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic                            m_tuser
);
    import pdc_pkg::*;

    // A stalled result keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Results that carry no valid entry report a zero pair.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[PAIR_W-1:0] == '0)
        else $error("invalid result carries a nonzero pair");

    // The stride is always a single power of two.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot(m_tdata[118:87]))
        else $error("stride is not a power of two");

    // The archive never holds more than the whole store.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[86:76] <= m_tdata[75:64])
        else $error("archive count exceeds total count");

    // The sequencer is busy in the cycle right after taking a request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while the previous one is in flight");

endmodule

bind progressive_decimation_capture pdc_checker u_pdc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> sim/progressive_decimation_capture_test.sv
// Self-checking testbench for the progressive decimation capture store.
module progressive_decimation_capture_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pdc_pkg::*;

    localparam int RDEPTH        = RECENT_DEPTH_DEF;
    localparam int ADEPTH        = ARCHIVE_DEPTH_DEF;
    localparam int FOLD          = RDEPTH / 2;
    localparam int RANDOM_ITEMS  = 1650;
    localparam int TAIL_ITEMS    = 150;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int REPORT_LIMIT  = 30;

    typedef struct {
        bit [31:0] rd_time;
        bit [31:0] rd_value;
        bit        rd_valid;
        bit [11:0] total;
        bit [10:0] archived;
        bit [31:0] stride;
    } capture_result_t;

    // Mirror of the capture store: recent ring, decimated archive and the
    // queue of results that the block still owes.
    class capture_store_model;
        bit [31:0]       rec_time [0:RDEPTH];
        bit [31:0]       rec_value [0:RDEPTH];
        bit [31:0]       arch_time [0:ADEPTH];
        bit [31:0]       arch_value [0:ADEPTH];
        int unsigned     rec_fill;
        int unsigned     arch_fill;
        bit [31:0]       phase;
        bit [31:0]       stride;
        int              failures;
        capture_result_t expected_results[$];

        function new();
            rec_fill  = 0;
            arch_fill = 0;
            phase     = 0;
            stride    = 1;
            failures  = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_failure();
            failures++;
        endfunction

        // One pair leaving the recent ring; the archive keeps one per stride.
        function void offer_archive(bit [31:0] t, bit [31:0] v);
            int unsigned w;
            phase++;
            if (phase < stride)
                return;
            phase = 0;
            if (arch_fill > ADEPTH)
                arch_fill = ADEPTH;
            arch_time[arch_fill]  = t;
            arch_value[arch_fill] = v;
            arch_fill++;
            if (arch_fill > ADEPTH) begin
                // Keep the odd positions, compacted to the front.
                w = 0;
                for (int unsigned r = 1; r < arch_fill; r += 2) begin
                    arch_time[w]  = arch_time[r];
                    arch_value[w] = arch_value[r];
                    w++;
                end
                arch_fill = w;
                stride = (stride >= STRIDE_MAX) ? STRIDE_MAX : stride << 1;
            end
        endfunction

        function void push_sample(bit [31:0] t, bit [31:0] v);
            if (rec_fill > RDEPTH)
                rec_fill = RDEPTH;
            rec_time[rec_fill]  = t;
            rec_value[rec_fill] = v;
            rec_fill++;
            if (rec_fill <= RDEPTH)
                return;
            for (int unsigned i = 0; i < FOLD; i++)
                offer_archive(rec_time[i], rec_value[i]);
            for (int unsigned i = FOLD; i < rec_fill; i++) begin
                rec_time[i - FOLD]  = rec_time[i];
                rec_value[i - FOLD] = rec_value[i];
            end
            rec_fill -= FOLD;
        endfunction

        // Called once per accepted request; queues the result it must cause.
        function void take_request(bit func, bit [31:0] t, bit [31:0] v, bit [10:0] idx);
            capture_result_t res;
            int unsigned     sum;
            res = '{default: 0};
            if (func == FUNC_PUSH) begin
                push_sample(t, v);
            end else begin
                sum = arch_fill + rec_fill;
                if (idx < arch_fill) begin
                    res.rd_time  = arch_time[idx];
                    res.rd_value = arch_value[idx];
                    res.rd_valid = 1;
                end else if (idx < sum) begin
                    res.rd_time  = rec_time[idx - arch_fill];
                    res.rd_value = rec_value[idx - arch_fill];
                    res.rd_valid = 1;
                end
            end
            sum          = arch_fill + rec_fill;
            res.total    = sum[11:0];
            res.archived = arch_fill[10:0];
            res.stride   = stride;
            expected_results.insert(expected_results.size(), res);
        endfunction

        function void compare_field(string label, bit [31:0] want, bit [31:0] got);
            if (want !== got) begin
                note_failure();
                if (failures <= REPORT_LIMIT)
                    $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h",
                             $time, label, want, got);
            end
        endfunction

        function void check_result(bit [M_TDATA_W-1:0] d, bit u);
            capture_result_t want;
            if (expected_results.size() == 0) begin
                note_failure();
                if (failures <= REPORT_LIMIT)
                    $display("%0t: unexpected result, expected none, actual 0x%030h",
                             $time, d);
                return;
            end
            want = expected_results[0];
            expected_results.delete(0);
            compare_field("read_time", want.rd_time, d[31:0]);
            compare_field("read_value", want.rd_value, d[63:32]);
            compare_field("read_valid", want.rd_valid, u);
            compare_field("total_count", want.total, d[75:64]);
            compare_field("archive_count", want.archived, d[86:76]);
            compare_field("stride_now", want.stride, d[118:87]);
            compare_field("tdata pad", 0, d[M_TDATA_W-1:119]);
        endfunction
    endclass

    logic                 aclk = 0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    capture_store_model model;
    bit                 idle_on = 1;
    int                 hold_requests = 0;
    int                 hold_served = 0;
    int                 hold_left = 0;
    int                 stall_left = 0;
    int                 cycles = 0;

    progressive_decimation_capture u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Both monitors sample at the edge, before any of this step's updates land.
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && s_tvalid && s_tready)
            model.take_request(s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[74:64]);
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid && m_tready)
            model.check_result(m_tdata, m_tuser);
    end

    // Receiver: random stall bursts, plus a long hold-off on request so that
    // the block fills up and has to stall its input side.
    always @(posedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 6);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Offers one request and returns at the edge where it is taken; tvalid
    // stays high into the next request unless an idle burst follows.
    task automatic send_request(bit func, bit [31:0] t, bit [31:0] v, bit [10:0] idx);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {5'b0, idx, v, t};
        do @(posedge aclk); while (s_tready !== 1'b1);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 7);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (model.pending() != 0);
    endtask

    // Mostly pushes, so the recent ring folds into the archive;
    // reads favor the ends of the stored range and the archive boundary.
    task automatic random_request();
        int unsigned sum;
        int unsigned arch;
        bit [10:0]   idx;
        sum  = model.arch_fill + model.rec_fill;
        arch = model.arch_fill;
        if ($urandom_range(0, 99) < 86) begin
            send_request(FUNC_PUSH, $urandom, $urandom, 11'($urandom_range(0, 2047)));
        end else begin
            case ($urandom_range(0, 7))
                0: idx = 11'($urandom_range(0, 2047));
                1: idx = 11'(sum);
                2: idx = 11'(arch);
                3: idx = (arch > 0) ? 11'(arch - 1) : 11'd0;
                4: idx = (sum > 0) ? 11'(sum - 1) : 11'd0;
                default: idx = (sum > 0) ? 11'($urandom_range(0, sum - 1)) : 11'd0;
            endcase
            send_request(FUNC_READ, $urandom, $urandom, idx);
        end
    endtask

    initial begin
        int  n;
        bit  in_tail;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = FUNC_PUSH;
        s_tdata  = '0;
        model    = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reads of an empty store, then all-zero, all-one and alternating
        // words, reads inside and past the stored range.
        send_request(FUNC_READ, 32'h0, 32'h0, 11'd0);
        send_request(FUNC_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd2047);
        send_request(FUNC_PUSH, 32'h0000_0000, 32'h0000_0000, 11'd0);
        send_request(FUNC_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd2047);
        send_request(FUNC_PUSH, 32'hAAAA_AAAA, 32'h5555_5555, 11'h2AA);
        send_request(FUNC_PUSH, 32'h5555_5555, 32'hAAAA_AAAA, 11'h555);
        send_request(FUNC_READ, 32'h0, 32'h0, 11'd0);
        send_request(FUNC_READ, 32'h0, 32'h0, 11'd1);
        send_request(FUNC_READ, 32'h0, 32'h0, 11'd3);
        send_request(FUNC_READ, 32'h0, 32'h0, 11'd4);
        send_request(FUNC_READ, 32'h0, 32'h0, 11'd2047);
        send_request(FUNC_READ, 32'h0, 32'h0, 11'd1024);
        send_request(FUNC_READ, 32'h0, 32'h0, 11'h555);
        send_request(FUNC_READ, 32'h0, 32'h0, 11'h2AA);
        send_request(FUNC_PUSH, $urandom, $urandom, 11'd0);
        send_request(FUNC_READ, 32'h0, 32'h0, 11'd4);

        // Random part, ending with a stretch free of idling.
        n       = 0;
        in_tail = 0;
        while (n < RANDOM_ITEMS) begin
            if (!in_tail && n % 100 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            if (n == 300 || n == 1300)
                hold_requests++;
            if (n == 800)
                wait_drained();
            if (n == RANDOM_ITEMS - TAIL_ITEMS) begin
                in_tail = 1;
                idle_on = 0;
            end
            random_request();
            n++;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (model.failures == 0 && model.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
hdl/pdc_pkg.sv
hdl/pdc_ram.sv
hdl/pdc_archive.sv
hdl/progressive_decimation_capture.sv
hdl/pdc_checker.sv
sim/progressive_decimation_capture_test.sv
